### rtl/rkc_pkg.sv
// ----------------------------------------------------------------------------
// rkc_pkg
// shared types and constants of the raster kernel convolution block
// ----------------------------------------------------------------------------
`default_nettype none

package rkc_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_KERNEL  = 7;
    localparam int LINE_ROWS   = 8;
    localparam int PIXEL_BITS  = 16;

    localparam int STORE_DEPTH = MAX_WIDTH * LINE_ROWS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int COEF_DEPTH  = MAX_KERNEL * MAX_KERNEL;
    localparam int COEF_AW     = $clog2(COEF_DEPTH);
    localparam int MAX_HALF    = (MAX_KERNEL - 1) / 2;
    localparam int KW          = $clog2(MAX_KERNEL);

    localparam int W_W         = 11;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 16;
    localparam int PROD_W      = ROW_W + W_W;
    localparam int POS_W       = PROD_W + 1;
    localparam int LAG_W       = 13;
    localparam int MUL_W       = 2 * PIXEL_BITS;
    localparam int ACC_W       = MUL_W + COEF_AW;

    localparam int CFG_AW      = 5;
    localparam int CFG_DW      = 32;

    // item modes
    localparam logic [1:0] MODE_COEF  = 2'd0;
    localparam logic [1:0] MODE_PIXEL = 2'd1;
    localparam logic [1:0] MODE_DRAIN = 2'd2;

    // register indexes
    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_KHALF  = 3'd2;
    localparam logic [2:0] REG_VMIN   = 3'd3;
    localparam logic [2:0] REG_VMAX   = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_KMUL, S_KADD, S_EADD, S_PCHK,
        S_INUPD, S_TAP, S_FLUSH, S_SAT, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        MSEL_IN, MSEL_EMIT, MSEL_TAP
    } t_msel;

    typedef struct packed {
        logic [W_W-1:0]          width;
        logic [ROW_W-1:0]        height;
        logic [1:0]              khalf;
        logic [PIXEL_BITS-1:0]   vmin;
        logic [PIXEL_BITS-1:0]   vmax;
    } t_cfg;

    typedef struct packed {
        logic  capture;
        logic  coef_wr;
        logic  prod_en;
        t_msel msel;
        logic  k_ld;
        logic  e_ld;
        logic  line_wr;
        logic  acc_clr;
        logic  tap_go;
        logic  sat;
        logic  out_ld;
        logic  in_upd;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       frame_done;
        logic       emit_ok;
        logic       tap_last;
        logic       pipe_busy;
        logic       out_free;
    } t_sts;

endpackage

`default_nettype wire

### rtl/rkc_ctrl.sv
// ----------------------------------------------------------------------------
// rkc_ctrl
// sequencer of one item: decode, position check, tap loop, output load
// ----------------------------------------------------------------------------
`default_nettype none

module rkc_ctrl import rkc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_DEC;
            end
            S_DEC: begin
                case (i_sts.mode)
                    MODE_PIXEL: n_state = i_sts.frame_done ? S_IDLE : S_KMUL;
                    MODE_DRAIN: n_state = i_sts.frame_done ? S_TAP : S_IDLE;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_KMUL:  n_state = S_KADD;
            S_KADD:  n_state = S_EADD;
            S_EADD:  n_state = S_PCHK;
            S_PCHK:  n_state = i_sts.emit_ok ? S_TAP : S_INUPD;
            S_INUPD: n_state = S_IDLE;
            S_TAP: begin
                if (i_sts.tap_last) n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (!i_sts.pipe_busy) n_state = S_SAT;
            end
            S_SAT:   n_state = S_OUT;
            S_OUT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.msel = MSEL_TAP;
        o_stall    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.capture = i_valid;
            end
            S_DEC: begin
                o_cmd.coef_wr = (i_sts.mode == MODE_COEF);
                o_cmd.acc_clr = (i_sts.mode == MODE_DRAIN) && i_sts.frame_done;
            end
            S_KMUL: begin
                o_cmd.prod_en = 1'b1;
                o_cmd.msel    = MSEL_IN;
            end
            S_KADD: begin
                o_cmd.k_ld    = 1'b1;
                o_cmd.prod_en = 1'b1;
                o_cmd.msel    = MSEL_EMIT;
            end
            S_EADD: begin
                o_cmd.e_ld    = 1'b1;
                o_cmd.line_wr = 1'b1;
            end
            S_PCHK:  o_cmd.acc_clr = i_sts.emit_ok;
            S_INUPD: o_cmd.in_upd  = 1'b1;
            S_TAP: begin
                o_cmd.tap_go  = 1'b1;
                o_cmd.prod_en = 1'b1;
            end
            S_FLUSH: o_cmd.sat    = 1'b0;
            S_SAT:   o_cmd.sat    = 1'b1;
            S_OUT:   o_cmd.out_ld = i_sts.out_free;
            default: o_cmd.sat    = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/rkc_dp.sv
// ----------------------------------------------------------------------------
// rkc_dp
// datapath: positions, line store, coefficient store, tap pipeline and mac
// ----------------------------------------------------------------------------
`default_nettype none

module rkc_dp import rkc_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cfg                         i_cfg,
    input  t_cmd                         i_cmd,
    output t_sts                         o_sts,
    input  logic [1:0]                   i_mode,
    input  logic signed [PIXEL_BITS-1:0] i_pixel,
    input  logic [COEF_AW-1:0]           i_coef_index,
    input  logic signed [PIXEL_BITS-1:0] i_coef_value,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic signed [PIXEL_BITS-1:0] o_result,
    output logic [COL_W-1:0]             o_out_x,
    output logic [ROW_W-1:0]             o_out_y,
    output logic                         o_frame_end
);

    // effective sizes
    logic [W_W-1:0]   w_eff, wm1;
    logic [ROW_W-1:0] hh_eff, hm1;
    logic [1:0]       h_eff;
    logic [KW-1:0]    side;
    logic [LAG_W-1:0] lag;

    always_comb begin
        if (i_cfg.width == '0)                  w_eff = W_W'(1);
        else if (i_cfg.width > W_W'(MAX_WIDTH)) w_eff = W_W'(MAX_WIDTH);
        else                                    w_eff = i_cfg.width;
        wm1    = w_eff - W_W'(1);
        hh_eff = (i_cfg.height == '0) ? ROW_W'(1) : i_cfg.height;
        hm1    = hh_eff - ROW_W'(1);
        if (i_cfg.khalf == 2'd0)                h_eff = 2'd1;
        else if (i_cfg.khalf > 2'(MAX_HALF))    h_eff = 2'(MAX_HALF);
        else                                    h_eff = i_cfg.khalf;
        side = KW'({h_eff, 1'b1});
        lag  = (h_eff[1] ? LAG_W'({w_eff, 1'b0}) : LAG_W'(0))
             + (h_eff[0] ? LAG_W'(w_eff) : LAG_W'(0)) + LAG_W'(h_eff);
    end

    // item and positions
    logic [1:0]                   r_mode;
    logic signed [PIXEL_BITS-1:0] r_pix_in, r_cv;
    logic [COEF_AW-1:0]           r_ci;
    logic [COL_W-1:0]             r_in_col, r_em_col;
    logic [ROW_W-1:0]             r_in_row, r_em_row;
    logic                         r_frame_done;
    logic                         last_in, last_em;

    assign last_in = ({1'b0, r_in_row} + 17'd1 >= {1'b0, hh_eff})
                  && ({1'b0, r_in_col} + W_W'(1) >= w_eff);
    assign last_em = ({1'b0, r_em_row} + 17'd1 >= {1'b0, hh_eff})
                  && ({1'b0, r_em_col} + W_W'(1) >= w_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_COEF;
        end else if (i_cmd.capture) begin
            r_mode <= i_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pix_in <= i_pixel;
            r_ci     <= i_coef_index;
            r_cv     <= i_coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_em_col     <= '0;
            r_em_row     <= '0;
            r_frame_done <= 1'b0;
        end else begin
            if ((i_cmd.out_ld && r_mode != MODE_DRAIN) || i_cmd.in_upd) begin
                if (last_in) begin
                    r_frame_done <= 1'b1;
                end else if ({1'b0, r_in_col} + W_W'(1) >= w_eff) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + ROW_W'(1);
                end else begin
                    r_in_col <= r_in_col + COL_W'(1);
                end
            end
            if (i_cmd.out_ld) begin
                if (r_mode == MODE_DRAIN && last_em) begin
                    r_in_col     <= '0;
                    r_in_row     <= '0;
                    r_em_col     <= '0;
                    r_em_row     <= '0;
                    r_frame_done <= 1'b0;
                end else if ({1'b0, r_em_col} + W_W'(1) >= w_eff) begin
                    r_em_col <= '0;
                    r_em_row <= r_em_row + ROW_W'(1);
                end else begin
                    r_em_col <= r_em_col + COL_W'(1);
                end
            end
        end
    end

    // tap counters and window coordinates
    logic [KW-1:0]      r_kx, r_ky;
    logic [W_W-1:0]     ex;
    logic [12:0]        tx;
    logic [COL_W-1:0]   sx;
    logic [ROW_W-1:0]   ey, sy;
    logic [17:0]        ty;
    logic [COEF_AW-1:0] cidx;
    logic               tap_last;

    always_comb begin
        ex = ({1'b0, r_em_col} > wm1) ? wm1 : {1'b0, r_em_col};
        tx = 13'(ex) + 13'(r_kx) - 13'(h_eff);
        if (tx[12])              sx = '0;
        else if (tx > 13'(wm1))  sx = wm1[COL_W-1:0];
        else                     sx = tx[COL_W-1:0];
        ey = (r_em_row > hm1) ? hm1 : r_em_row;
        ty = 18'(ey) + 18'(r_ky) - 18'(h_eff);
        if (ty[17])              sy = '0;
        else if (ty > 18'(hm1))  sy = hm1;
        else                     sy = ty[ROW_W-1:0];
        cidx = COEF_AW'(COEF_AW'(r_ky) * COEF_AW'(side)) + COEF_AW'(r_kx);
    end

    assign tap_last = (r_kx == side - KW'(1)) && (r_ky == side - KW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_kx <= '0;
            r_ky <= '0;
        end else if (i_cmd.tap_go) begin
            if (r_kx == side - KW'(1)) begin
                r_kx <= '0;
                r_ky <= r_ky + KW'(1);
            end else begin
                r_kx <= r_kx + KW'(1);
            end
        end
    end

    // shared row times width multiplier
    logic [ROW_W-1:0]  m_a;
    logic [PROD_W-1:0] r_prod;
    logic [POS_W-1:0]  r_k, r_e;

    always_comb begin
        unique case (i_cmd.msel)
            MSEL_IN:   m_a = r_in_row;
            MSEL_EMIT: m_a = r_em_row;
            default:   m_a = sy;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prod_en) r_prod <= PROD_W'(m_a) * PROD_W'(w_eff);
        if (i_cmd.k_ld)    r_k    <= POS_W'(r_prod) + POS_W'(r_in_col);
        if (i_cmd.e_ld)    r_e    <= POS_W'(r_prod) + POS_W'(r_em_col);
    end

    // memories
    logic signed [PIXEL_BITS-1:0] line_mem [STORE_DEPTH];
    logic signed [PIXEL_BITS-1:0] coef_mem [COEF_DEPTH];
    logic [COEF_DEPTH-1:0]        r_cvalid;
    logic signed [PIXEL_BITS-1:0] r_lpix, r_cdat;
    logic                         r_cval;
    logic [COL_W-1:0]             r_sx;
    logic [COEF_AW-1:0]           r_tci;
    logic [STORE_AW-1:0]          rd_addr;

    assign rd_addr = r_prod[STORE_AW-1:0] + STORE_AW'(r_sx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.line_wr) line_mem[r_k[STORE_AW-1:0]] <= r_pix_in;
        r_lpix <= line_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_wr && r_ci < COEF_AW'(COEF_DEPTH)) coef_mem[r_ci] <= r_cv;
        r_cdat <= coef_mem[r_tci];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
        end else if (i_cmd.coef_wr && r_ci < COEF_AW'(COEF_DEPTH)) begin
            r_cvalid[r_ci] <= 1'b1;
        end
    end

    // tap pipeline: issue, read, multiply, accumulate
    logic                     r_va, r_vb, r_vc;
    logic signed [MUL_W-1:0]  r_mul;
    logic signed [ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            r_va <= i_cmd.tap_go;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tap_go) begin
            r_sx  <= sx;
            r_tci <= cidx;
        end
        r_cval <= r_cvalid[r_tci];
        r_mul  <= r_lpix * (r_cval ? r_cdat : PIXEL_BITS'(0));
        if (i_cmd.acc_clr)  r_acc <= '0;
        else if (r_vc)      r_acc <= r_acc + ACC_W'(r_mul);
    end

    // saturation and output register
    logic signed [ACC_W-1:0]      vmin_e, vmax_e, t_hi, t_lo;
    logic signed [PIXEL_BITS-1:0] r_res;
    logic                         r_ovalid;
    logic                         out_free;

    always_comb begin
        vmin_e = ACC_W'($signed(i_cfg.vmin));
        vmax_e = ACC_W'($signed(i_cfg.vmax));
        t_hi   = (r_acc > vmax_e) ? vmax_e : r_acc;
        t_lo   = (t_hi < vmin_e) ? vmin_e : t_hi;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sat) r_res <= t_lo[PIXEL_BITS-1:0];
    end

    assign out_free = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            o_result    <= r_res;
            o_out_x     <= r_em_col;
            o_out_y     <= r_em_row;
            o_frame_end <= (r_mode == MODE_DRAIN) && last_em;
        end
    end

    assign o_valid = r_ovalid;

    always_comb begin
        o_sts.mode       = r_mode;
        o_sts.frame_done = r_frame_done;
        o_sts.emit_ok    = (r_e + POS_W'(lag) <= r_k) && !last_em;
        o_sts.tap_last   = tap_last;
        o_sts.pipe_busy  = r_va || r_vb || r_vc;
        o_sts.out_free   = out_free;
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_ld |-> out_free)
        else $error("pending result overwritten");

    a_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sat || i_cmd.out_ld) |-> !(r_va || r_vb || r_vc))
        else $error("result taken before all taps accumulated");

    a_frame_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_frame_done) |-> $past(i_cmd.in_upd || i_cmd.out_ld))
        else $error("frame done set without a position update");
`endif

endmodule

`default_nettype wire

### rtl/raster_kernel_convolution_top.sv
// ----------------------------------------------------------------------------
// raster_kernel_convolution_top
// 2d convolution of a raster pixel stream with an odd square kernel and
// replicated borders, saturated to programmable bounds
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  input   | in        | i_valid / o_stall   | mode, pixel, coef index, value
//  output  | out       | o_valid / i_stall   | result, out x, out y, frame end
//  config  | in        | apb psel / penable  | five registers at 4*index
//
//  a coefficient write or an ignored item only passes through decode
//  a pixel without a result stores itself and updates its input position; one
//  that produces a result then walks the window taps, and a drain does so at
//  once, on the single shared multiply-accumulate, one tap per cycle out of
//  the line store read port, followed by a flush of the tap pipeline
//  a result waits in the output register; the next item is taken meanwhile
//  and only stalls in its final step if that register is still full
//  reset is synchronous active low and clears positions and coefficients
// ----------------------------------------------------------------------------
`default_nettype none

module raster_kernel_convolution_top import rkc_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_AW-1:0]            paddr,
    input  logic [CFG_DW-1:0]            pwdata,
    output logic [CFG_DW-1:0]            prdata,
    output logic                         pready,
    // input items
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_mode,
    input  logic signed [PIXEL_BITS-1:0] i_pixel,
    input  logic [COEF_AW-1:0]           i_coef_index,
    input  logic signed [PIXEL_BITS-1:0] i_coef_value,
    // result items
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [PIXEL_BITS-1:0] o_result,
    output logic [COL_W-1:0]             o_out_x,
    output logic [ROW_W-1:0]             o_out_y,
    output logic                         o_frame_end
);

    // configuration registers
    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    // write lands in the access phase of the transfer
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= W_W'(640);
            r_cfg.height <= ROW_W'(480);
            r_cfg.khalf  <= 2'd1;
            r_cfg.vmin   <= 16'h8000;
            r_cfg.vmax   <= 16'h7fff;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_WIDTH:  r_cfg.width  <= pwdata[W_W-1:0];
                REG_HEIGHT: r_cfg.height <= pwdata[ROW_W-1:0];
                REG_KHALF:  r_cfg.khalf  <= pwdata[1:0];
                REG_VMIN:   r_cfg.vmin   <= pwdata[PIXEL_BITS-1:0];
                REG_VMAX:   r_cfg.vmax   <= pwdata[PIXEL_BITS-1:0];
                default:    ;   // addresses past the register list
            endcase
        end
    end

    // read back, bounds returned as their raw 16 bits
    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = CFG_DW'(r_cfg.width);
            REG_HEIGHT: prdata = CFG_DW'(r_cfg.height);
            REG_KHALF:  prdata = CFG_DW'(r_cfg.khalf);
            REG_VMIN:   prdata = CFG_DW'(r_cfg.vmin);
            REG_VMAX:   prdata = CFG_DW'(r_cfg.vmax);
            default:    prdata = '0;
        endcase
    end

    // controller and datapath talk only through these
    t_cmd cmd;
    t_sts sts;

    rkc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rkc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_mode       (i_mode),
        .i_pixel      (i_pixel),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_result     (o_result),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_frame_end  (o_frame_end)
    );

endmodule

`default_nettype wire

### test/raster_kernel_convolution_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_kernel_convolution_top_tb
// drives frames of raster pixels, coefficient writes, drains and stray items
// into the convolution block under random sizes, kernels and saturation bounds;
// a scoreboard predicts every result transfer and compares it field by field
// ----------------------------------------------------------------------------
`default_nettype none

module raster_kernel_convolution_top_tb;
    import rkc_pkg::*;

    localparam int CLK_HALF   = 2;
    localparam int CYCLE_MAX  = 3000000;
    localparam int SETTLE     = 100;     // longer than one drain of a 7x7 window
    localparam int RAND_ITEMS = 750;
    localparam logic [1:0] MODE_BAD = 2'd3;

    typedef struct {
        logic signed [PIXEL_BITS-1:0] result;
        logic [COL_W-1:0]             x;
        logic [ROW_W-1:0]             y;
        logic                         frame_end;
    } conv_out_t;

    // clock, reset and block ports
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [CFG_DW-1:0] pwdata = '0;
    logic [CFG_DW-1:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_mode = MODE_COEF;
    logic signed [PIXEL_BITS-1:0] i_pixel = '0;
    logic [COEF_AW-1:0] i_coef_index = '0;
    logic signed [PIXEL_BITS-1:0] i_coef_value = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [PIXEL_BITS-1:0] o_result;
    logic [COL_W-1:0] o_out_x;
    logic [ROW_W-1:0] o_out_y;
    logic o_frame_end;

    int  n_errors = 0;
    int  n_items  = 0;
    int  n_cycles = 0;
    bit  quiet    = 1'b0;   // no gaps and no new stalls while set

    raster_kernel_convolution_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall), .i_mode(i_mode), .i_pixel(i_pixel),
        .i_coef_index(i_coef_index), .i_coef_value(i_coef_value),
        .o_valid(o_valid), .i_stall(i_stall), .o_result(o_result),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_frame_end(o_frame_end)
    );

    task automatic report(input string what);
        n_errors++;
        $display("mismatch at cycle %0d: %s", n_cycles, what);
    endtask

    // ------------------------------------------------------------------------
    // scoreboard: own copy of registers, line store and positions
    // ------------------------------------------------------------------------
    class conv_scoreboard;
        int               reg_w, reg_h, reg_half;
        int               bound_lo, bound_hi;
        int               lines[STORE_DEPTH];
        int               coefs[COEF_DEPTH];
        int               in_col, in_row, emit_col, emit_row;
        bit               frame_done;
        conv_out_t        pending[$];

        function new();
            reg_w = 640; reg_h = 480; reg_half = 1;
            bound_lo = -32768; bound_hi = 32767;
            foreach (lines[i]) lines[i] = 0;
            foreach (coefs[i]) coefs[i] = 0;
            in_col = 0; in_row = 0; emit_col = 0; emit_row = 0;
            frame_done = 1'b0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_WIDTH:  reg_w = int'(v[W_W-1:0]);
                REG_HEIGHT: reg_h = int'(v[ROW_W-1:0]);
                REG_KHALF:  reg_half = int'(v[1:0]);
                REG_VMIN:   bound_lo = int'($signed(v[15:0]));
                REG_VMAX:   bound_hi = int'($signed(v[15:0]));
                default: ;
            endcase
        endfunction

        function int eff_w();
            if (reg_w == 0) return 1;
            return (reg_w > MAX_WIDTH) ? MAX_WIDTH : reg_w;
        endfunction

        function int eff_h();
            return (reg_h == 0) ? 1 : reg_h;
        endfunction

        function int eff_half();
            if (reg_half < 1) return 1;
            return (reg_half > MAX_HALF) ? MAX_HALF : reg_half;
        endfunction

        function int clip(int v, int lo, int hi);
            if (v < lo) v = lo;
            if (v > hi) v = hi;
            return v;
        endfunction

        function bit at_last(int col, int row);
            return (row + 1 >= eff_h()) && (col + 1 >= eff_w());
        endfunction

        function void step_emit();
            if (emit_col + 1 >= eff_w()) begin
                emit_col = 0;
                emit_row++;
            end else begin
                emit_col++;
            end
        endfunction

        // window sum of the next output pixel, saturated max first
        function void convolve(bit last);
            int w, hh, h, side, ex, ey, sx, sy;
            longint acc;
            conv_out_t o;
            w = eff_w(); hh = eff_h(); h = eff_half();
            side = 2 * h + 1;
            ex = clip(emit_col, 0, w - 1);
            ey = clip(emit_row, 0, hh - 1);
            acc = 0;
            for (int ky = 0; ky < side; ky++)
                for (int kx = 0; kx < side; kx++) begin
                    sx = clip(ex + kx - h, 0, w - 1);
                    sy = clip(ey + ky - h, 0, hh - 1);
                    acc += longint'(coefs[ky * side + kx]) *
                           longint'(lines[(sy * w + sx) % STORE_DEPTH]);
                end
            if (acc > bound_hi) acc = bound_hi;
            if (acc < bound_lo) acc = bound_lo;
            o.result = acc[15:0];
            o.x = emit_col[COL_W-1:0];
            o.y = emit_row[ROW_W-1:0];
            o.frame_end = last;
            pending.push_back(o);
        endfunction

        // accepted input transfer
        function void note_item(logic [1:0] mode, logic signed [15:0] pix,
                                logic [5:0] idx, logic signed [15:0] val);
            longint k, lag, e;
            bit last;
            case (mode)
                MODE_COEF: begin
                    if (idx < COEF_DEPTH) coefs[idx] = int'(val);
                end
                MODE_PIXEL: begin
                    if (!frame_done) begin
                        k = longint'(in_row) * eff_w() + in_col;
                        lines[k % STORE_DEPTH] = int'(pix);
                        lag = longint'(eff_half()) * eff_w() + eff_half();
                        e = longint'(emit_row) * eff_w() + emit_col;
                        if (k >= lag && e <= k - lag && !at_last(emit_col, emit_row)) begin
                            convolve(1'b0);
                            step_emit();
                        end
                        if (at_last(in_col, in_row))
                            frame_done = 1'b1;
                        else if (in_col + 1 >= eff_w()) begin
                            in_col = 0;
                            in_row++;
                        end else
                            in_col++;
                    end
                end
                MODE_DRAIN: begin
                    if (frame_done) begin
                        last = at_last(emit_col, emit_row);
                        convolve(last);
                        if (last) begin
                            in_col = 0; in_row = 0; emit_col = 0; emit_row = 0;
                            frame_done = 1'b0;
                        end else
                            step_emit();
                    end
                end
                default: ;
            endcase
        endfunction

        // accepted result transfer against the oldest expectation
        task check_result(conv_out_t got);
            conv_out_t want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %0d at (%0d,%0d)",
                                 got.result, got.x, got.y));
                return;
            end
            want = pending.pop_front();
            if (got.result !== want.result)
                report($sformatf("result at (%0d,%0d): got %0d want %0d",
                                 want.x, want.y, got.result, want.result));
            if (got.x !== want.x || got.y !== want.y)
                report($sformatf("position: got (%0d,%0d) want (%0d,%0d)",
                                 got.x, got.y, want.x, want.y));
            if (got.frame_end !== want.frame_end)
                report($sformatf("frame end at (%0d,%0d): got %0b want %0b",
                                 want.x, want.y, got.frame_end, want.frame_end));
        endtask
    endclass

    conv_scoreboard sb = new();

    // clock
    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: sample the transfer first, then pick the next stall
    int stall_left = 0;
    always @(posedge i_clk) begin
        int r;
        conv_out_t got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.result = o_result;
            got.x = o_out_x;
            got.y = o_out_y;
            got.frame_end = o_frame_end;
            sb.check_result(got);
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
        end else if (!quiet) begin
            r = $urandom_range(0, 99);
            if (r < 3)       stall_left = $urandom_range(20, 40);
            else if (r < 20) stall_left = $urandom_range(1, 3);
        end
        i_stall <= (stall_left > 0);
    end

    // one input transfer, preceded by a random gap; returns at the accepting edge
    task automatic send_item(input logic [1:0] mode, input logic signed [15:0] pix,
                             input logic [5:0] idx, input logic signed [15:0] val);
        int r, gap;
        r = $urandom_range(0, 99);
        gap = quiet ? 0 : (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3)
                                                 : $urandom_range(10, 40);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_pixel <= pix;
        i_coef_index <= idx;
        i_coef_value <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_item(mode, pix, idx, val);
        n_items++;
    endtask

    // register write: setup cycle then access cycle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
        i_valid <= 1'b0;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_AW'(idx) << 2;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.set_reg(idx, v);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // all results in, then enough cycles for a silent item to finish
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_value(bit wide);
        if (wide) return 16'($urandom);
        return 16'($signed($urandom_range(0, 16)) - 8);
    endfunction

    // one stray item: mode 3, bad coefficient index, drain or coefficient
    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_item(MODE_BAD, 16'($urandom), 6'($urandom), 16'($urandom));
            1: send_item(MODE_COEF, 16'($urandom), 6'($urandom_range(49, 63)),
                         16'($urandom));
            2: send_item(MODE_DRAIN, 16'($urandom), 6'($urandom), 16'($urandom));
            default: send_item(MODE_COEF, 16'($urandom), 6'($urandom_range(0, 48)),
                               rand_value(1'b0));
        endcase
    endtask

    // configure, load the kernel, stream one frame and drain it
    task automatic run_frame(input int w, input int h, input int half,
                             input int lo, input int hi, input bit wide);
        int side, count;
        wait_idle();
        write_reg(REG_WIDTH, 32'(w));
        write_reg(REG_HEIGHT, 32'(h));
        write_reg(REG_KHALF, 32'(half));
        write_reg(REG_VMIN, {16'h0, 16'(lo)});
        write_reg(REG_VMAX, {16'h0, 16'(hi)});
        side = 2 * sb.eff_half() + 1;
        // sometimes keep stale coefficients from an earlier kernel size
        if ($urandom_range(0, 3) != 0)
            for (int i = 0; i < side * side; i++)
                send_item(MODE_COEF, 16'($urandom), 6'(i), rand_value(wide));
        count = sb.eff_w() * sb.eff_h();
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 19) == 0) send_noise();
            send_item(MODE_PIXEL, rand_value(wide || $urandom_range(0, 3) == 0),
                      6'($urandom), 16'($urandom));
        end
        // pixels after the frame is complete are ignored
        repeat ($urandom_range(0, 2)) send_item(MODE_PIXEL, 16'($urandom),
                                                6'($urandom), 16'($urandom));
        while (sb.frame_done) begin
            if ($urandom_range(0, 15) == 0) send_noise();
            send_item(MODE_DRAIN, 16'($urandom), 6'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        int w, h, lo, hi;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes of pixels and coefficients on a small frame
        write_reg(REG_WIDTH, 32'd3);
        write_reg(REG_HEIGHT, 32'd2);
        write_reg(REG_KHALF, 32'd1);
        write_reg(REG_VMIN, {16'h0, 16'h8000});
        write_reg(REG_VMAX, {16'h0, 16'h7fff});
        send_item(MODE_COEF, '0, 6'd0, 16'sh8000);
        send_item(MODE_COEF, '0, 6'd8, 16'sh7fff);
        send_item(MODE_COEF, '0, 6'd4, 16'sd1);
        send_item(MODE_COEF, '0, 6'd63, 16'sh5555);   // beyond the store
        send_item(MODE_BAD, 16'sh7fff, 6'd1, 16'sd3);
        send_item(MODE_DRAIN, '0, '0, '0);            // ignored while arriving
        send_item(MODE_PIXEL, 16'sh8000, '0, '0);
        send_item(MODE_PIXEL, 16'sh7fff, '0, '0);
        send_item(MODE_PIXEL, 16'sh0000, '0, '0);
        send_item(MODE_PIXEL, 16'shffff, '0, '0);
        send_item(MODE_PIXEL, 16'sh8000, '0, '0);
        send_item(MODE_PIXEL, 16'sh7fff, '0, '0);
        send_item(MODE_PIXEL, 16'sh1234, '0, '0);     // after frame end: ignored
        while (sb.frame_done) send_item(MODE_DRAIN, '0, '0, '0);

        // out-of-range registers and extreme sizes
        run_frame(0, 0, 0, -32768, 32767, 1'b1);

        // width above the maximum, then a narrower width mid-frame
        wait_idle();
        write_reg(REG_WIDTH, 32'd2047);
        write_reg(REG_HEIGHT, 32'd1);
        write_reg(REG_KHALF, 32'd3);
        repeat (16) send_item(MODE_PIXEL, rand_value(1'b1), '0, '0);
        wait_idle();
        write_reg(REG_WIDTH, 32'd5);
        while (!sb.frame_done) send_item(MODE_PIXEL, rand_value(1'b1), '0, '0);
        while (sb.frame_done) send_item(MODE_DRAIN, '0, '0, '0);

        run_frame(5, 3, 3, 32767, -32768, 1'b1);      // min above max wins
        run_frame(7, 7, 2, -100, 100, 1'b1);
        wait_idle();
        write_reg(REG_HEIGHT, 32'd65535);

        while (n_items < RAND_ITEMS) begin
            quiet = ($urandom_range(0, 3) == 0);
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 14);
            h = $urandom_range(1, 9);
            if ($urandom_range(0, 2) == 0) begin
                lo = $signed(16'($urandom));
                hi = $signed(16'($urandom));
            end else begin
                lo = -32768;
                hi = 32767;
            end
            run_frame(w, h, $urandom_range(0, 3), lo, hi, $urandom_range(0, 1));
        end

        quiet = 1'b0;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
